[hw/rtl/stbs_pkg.sv]
`timescale 1ns / 1ps

package stbs_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = IDX_W + 1;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned VAL_W       = 32;

  // operation codes of a request
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic wr_en;     // store the entry of a write request
    logic start;     // latch search key and initial bounds
    logic step;      // narrow the bounds after an unequal probe
    logic res_load;  // capture the outcome of the search
    logic res_hit;   // outcome is a hit
    logic out_load;  // move the outcome into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_range;  // search range is not empty
    logic key_eq;    // probed key equals the search key
    logic out_free;  // output register can take a result this cycle
  } sts_t;

  // floor((lo + hi - 1) / 2), the probe index for the range [lo, hi)
  function automatic logic [IDX_W-1:0] mid_of(input logic [CNT_W-1:0] lo,
                                               input logic [CNT_W-1:0] hi);
    logic [CNT_W:0] sum;
    sum = {1'b0, lo} + {1'b0, hi} - {{CNT_W{1'b0}}, 1'b1};
    return sum[IDX_W:1];
  endfunction

endpackage

[hw/rtl/stbs_ctrl.sv]
`timescale 1ns / 1ps

module stbs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          operation_i,
  output logic          in_stall_o,
  input  stbs_pkg::sts_t sts_i,
  output stbs_pkg::cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_PROBE  = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (operation_i == stbs_pkg::OP_LOOKUP) begin
            cmd_o.start = 1'b1;
            state_d     = S_PROBE;
          end else begin
            cmd_o.wr_en = 1'b1;
          end
        end
      end
      S_PROBE: begin
        if (sts_i.in_range && !sts_i.key_eq) begin
          cmd_o.step = 1'b1;
        end else begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_hit  = sts_i.in_range;
          state_d        = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hw/rtl/stbs_dp.sv]
`timescale 1ns / 1ps

module stbs_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  stbs_pkg::cmd_t                 cmd_i,
  output stbs_pkg::sts_t                 sts_o,
  input  logic [stbs_pkg::IDX_W-1:0]     entry_index_i,
  input  logic [stbs_pkg::KEY_W-1:0]     entry_key_i,
  input  logic [stbs_pkg::VAL_W-1:0]     entry_value_i,
  input  logic                           cfg_we_i,
  input  logic [stbs_pkg::CNT_W-1:0]     cfg_wdata_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           hit_o,
  output logic [stbs_pkg::KEY_W-1:0]     found_key_o,
  output logic [stbs_pkg::VAL_W-1:0]     found_value_o
);

  localparam logic [stbs_pkg::CNT_W-1:0] DepthCnt = stbs_pkg::CNT_W'(stbs_pkg::TABLE_DEPTH);

  stbs_pkg::entry_t                mem_q [stbs_pkg::TABLE_DEPTH];
  stbs_pkg::entry_t                rd_q;
  logic [stbs_pkg::CNT_W-1:0]      count_q;
  logic [stbs_pkg::KEY_W-1:0]      key_q;
  logic [stbs_pkg::CNT_W-1:0]      lo_q, lo_d, hi_q, hi_d, hi_init;
  logic [stbs_pkg::IDX_W-1:0]      mid_q, rd_addr;
  logic                            key_lt;
  logic                            res_hit_q;
  logic [stbs_pkg::KEY_W-1:0]      res_key_q;
  logic [stbs_pkg::VAL_W-1:0]      res_val_q;
  logic                            out_valid_q;
  logic                            out_hit_q;
  logic [stbs_pkg::KEY_W-1:0]      out_key_q;
  logic [stbs_pkg::VAL_W-1:0]      out_val_q;

  // count saturates at the table depth
  assign hi_init = (count_q > DepthCnt) ? DepthCnt : count_q;

  assign key_lt          = key_q < rd_q.key;
  assign sts_o.in_range  = lo_q < hi_q;
  assign sts_o.key_eq    = key_q == rd_q.key;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (cmd_i.start) begin
      lo_d = '0;
      hi_d = hi_init;
    end else if (cmd_i.step) begin
      if (key_lt) begin
        hi_d = {1'b0, mid_q};
      end else begin
        lo_d = {1'b0, mid_q} + stbs_pkg::CNT_W'(1);
      end
    end
  end

  assign rd_addr = stbs_pkg::mid_of(lo_d, hi_d);

  // table memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[entry_index_i] <= '{key: entry_key_i, val: entry_value_i};
    end
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= rd_addr;
    if (cmd_i.start) begin
      key_q <= entry_key_i;
    end
    if (cmd_i.res_load) begin
      res_hit_q <= cmd_i.res_hit;
      res_key_q <= cmd_i.res_hit ? rd_q.key : '0;
      res_val_q <= cmd_i.res_hit ? rd_q.val : '0;
    end
    if (cmd_i.out_load) begin
      out_hit_q <= res_hit_q;
      out_key_q <= res_key_q;
      out_val_q <= res_val_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = out_hit_q;
  assign found_key_o   = out_key_q;
  assign found_value_o = out_val_q;

endmodule

[hw/rtl/sorted_table_binary_search_unit.sv]
`timescale 1ns / 1ps

// Sorted key/value table with lookup by bisection. A write request (operation 0)
// stores key and value at entry_index and gives no result. A lookup request
// (operation 1) searches entries 0 to entry_count-1, which must hold keys in
// ascending order, and returns one result: hit with the matching key and
// value, or zeros on a miss. entry_count is set through cfg_we_i and
// cfg_wdata_i and saturates at the table depth; the user must set it only
// while the block is idle, and the block itself does not enforce this. A lookup
// is an accept step, one probe per table read (at most 11 probes for 1024
// entries, that is floor(log2(count)) + 1), one more probe step to see an
// empty range on a miss and a step to hand the result to the output register,
// bound by the single read port of the table memory, since each probe address
// depends on the key read by the probe before it. The input channel is stalled
// for the length of a lookup. A finished result waits in the output register,
// so further write requests and the next lookup are taken while it is still
// stalled downstream. Entries are undefined until written and a lookup must not probe an unwritten one.

module sorted_table_binary_search_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           operation_i,
  input  logic [stbs_pkg::IDX_W-1:0]     entry_index_i,
  input  logic [stbs_pkg::KEY_W-1:0]     entry_key_i,
  input  logic [stbs_pkg::VAL_W-1:0]     entry_value_i,
  // entry_count register
  input  logic                           cfg_we_i,
  input  logic [stbs_pkg::CNT_W-1:0]     cfg_wdata_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           hit_o,
  output logic [stbs_pkg::KEY_W-1:0]     found_key_o,
  output logic [stbs_pkg::VAL_W-1:0]     found_value_o
);

  stbs_pkg::cmd_t cmd;
  stbs_pkg::sts_t sts;

  // sequencer: idle, probe loop, result hand-over
  stbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .in_stall_o  (in_stall_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // table memory, search bounds, key compare and output register
  stbs_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .entry_index_i (entry_index_i),
    .entry_key_i   (entry_key_i),
    .entry_value_i (entry_value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .hit_o         (hit_o),
    .found_key_o   (found_key_o),
    .found_value_o (found_value_o)
  );

endmodule

[hw/rtl/stbs_chk.sv]
`timescale 1ns / 1ps

module stbs_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           operation_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic                           hit_o,
  input logic [stbs_pkg::KEY_W-1:0]     found_key_o,
  input logic [stbs_pkg::VAL_W-1:0]     found_value_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(hit_o) && $stable(found_key_o) && $stable(found_value_o))
    else $error("stalled result changed");

  // a lookup keeps the request side busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && operation_i == stbs_pkg::OP_LOOKUP |=> in_stall_o)
    else $error("request taken during a lookup");

  // a write finishes in its accept cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && operation_i == stbs_pkg::OP_WRITE |=> !in_stall_o)
    else $error("write request blocked the channel");

  // a new result only comes out of a running lookup
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a lookup");

endmodule

bind sorted_table_binary_search_unit stbs_chk u_chk (.*);

[tb/tb_sorted_table_binary_search_unit.sv]
`timescale 1ns / 1ps

module tb_sorted_table_binary_search_unit;
  import stbs_pkg::*;

  // request and result as the testbench sees them
  typedef struct packed {
    logic             op;
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
  } request_t;

  typedef struct packed {
    logic             hit;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
  } result_t;

  localparam int unsigned REQUEST_TARGET = 800;
  // a lookup with the gaps on each side, or a register update, leaves far
  // fewer quiet cycles than this
  localparam int unsigned QUIET_LIMIT    = 2000;
  // settling time before a register write, above the worst lookup latency
  localparam int unsigned SETTLE_CYCLES  = 20;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             in_valid_i    = 1'b0;
  logic             in_stall_o;
  logic             operation_i   = OP_WRITE;
  logic [IDX_W-1:0] entry_index_i = '0;
  logic [KEY_W-1:0] entry_key_i   = '0;
  logic [VAL_W-1:0] entry_value_i = '0;
  logic             cfg_we_i      = 1'b0;
  logic [CNT_W-1:0] cfg_wdata_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i   = 1'b0;
  logic             hit_o;
  logic [KEY_W-1:0] found_key_o;
  logic [VAL_W-1:0] found_value_o;

  sorted_table_binary_search_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .entry_index_i (entry_index_i),
    .entry_key_i   (entry_key_i),
    .entry_value_i (entry_value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .hit_o         (hit_o),
    .found_key_o   (found_key_o),
    .found_value_o (found_value_o)
  );

  // ---------------------------------------------------------------------
  // predictor state: the table as the block holds it after each accepted
  // request, and the entry count register
  // ---------------------------------------------------------------------
  logic [KEY_W-1:0] table_key [TABLE_DEPTH];
  logic [VAL_W-1:0] table_val [TABLE_DEPTH];
  int unsigned      entry_count_q = 0;
  result_t          lookup_answers [$];

  // ---------------------------------------------------------------------
  // stimulus planning state, ahead of the block: what has been queued so far,
  // which entries were written in the current phase, and the sorted table
  // the current phase aims at
  // ---------------------------------------------------------------------
  logic [KEY_W-1:0] plan_key   [TABLE_DEPTH];
  logic [VAL_W-1:0] plan_val   [TABLE_DEPTH];
  bit               plan_fresh [TABLE_DEPTH];
  logic [KEY_W-1:0] goal_key   [TABLE_DEPTH];
  logic [VAL_W-1:0] goal_val   [TABLE_DEPTH];
  int unsigned      plan_n = 0;
  int unsigned      n_queued = 0;
  request_t         pending_requests [$];

  // pacing, changed only between phases
  int unsigned      snd_max_gap   = 5;
  int unsigned      rcv_max_stall = 5;

  int unsigned      err_cnt      = 0;
  int unsigned      quiet_cycles = 0;
  int unsigned      gap_left     = 0;
  int unsigned      rcv_hold     = 0;
  request_t         cur_req;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // bisection over entries 0 to count-1, count saturated at the table depth;
  // the first equal key on the probe path wins, a miss returns zeros
  function automatic result_t search_table(input logic [KEY_W-1:0] key);
    int      lo;
    int      hi;
    int      mid;
    bit      done;
    result_t r;
    r    = '0;
    lo   = 0;
    hi   = ((entry_count_q > TABLE_DEPTH) ? int'(TABLE_DEPTH) : int'(entry_count_q)) - 1;
    done = 1'b0;
    while (lo <= hi && !done) begin
      mid = (lo + hi) / 2;
      if (key < table_key[mid]) begin
        hi = mid - 1;
      end else if (key > table_key[mid]) begin
        lo = mid + 1;
      end else begin
        r.hit = 1'b1;
        r.key = table_key[mid];
        r.val = table_val[mid];
        done  = 1'b1;
      end
    end
    return r;
  endfunction

  // update the table copy, or queue the answer of a lookup
  function automatic void record_request(input request_t req);
    if (req.op == OP_WRITE) begin
      table_key[req.idx] = req.key;
      table_val[req.idx] = req.val;
    end else begin
      lookup_answers.push_back(search_table(req.key));
    end
  endfunction

  task automatic queue_write(input logic [IDX_W-1:0] idx, input logic [KEY_W-1:0] key,
                             input logic [VAL_W-1:0] val);
    request_t req;
    req.op   = OP_WRITE;
    req.idx  = idx;
    req.key  = key;
    req.val  = val;
    plan_key[idx]   = key;
    plan_val[idx]   = val;
    plan_fresh[idx] = 1'b1;
    pending_requests.push_back(req);
    n_queued++;
  endtask

  // walk the probe path ahead of time; any probed entry not yet written in
  // this phase gets its planned content first, so no lookup reads an
  // entry that was never written
  task automatic queue_lookup(input logic [KEY_W-1:0] key);
    int       lo;
    int       hi;
    int       mid;
    bit       done;
    request_t req;
    lo   = 0;
    hi   = int'(plan_n) - 1;
    done = 1'b0;
    while (lo <= hi && !done) begin
      mid = (lo + hi) / 2;
      if (!plan_fresh[mid]) queue_write(mid[IDX_W-1:0], goal_key[mid], goal_val[mid]);
      if (key < plan_key[mid]) begin
        hi = mid - 1;
      end else if (key > plan_key[mid]) begin
        lo = mid + 1;
      end else begin
        done = 1'b1;
      end
    end
    // index and value are don't-care on a lookup, so let them wander
    req.op  = OP_LOOKUP;
    req.idx = IDX_W'($urandom);
    req.key = key;
    req.val = $urandom;
    pending_requests.push_back(req);
    n_queued++;
  endtask

  // the sender holds off until every answer is back and the block has
  // settled; register writes only happen after this
  task automatic wait_idle();
    while (pending_requests.size() != 0 || in_valid_i || lookup_answers.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_entry_count(input int unsigned n);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= n[CNT_W-1:0];
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    entry_count_q  = n;
    plan_n         = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
  endtask

  // ---------------------------------------------------------------------
  // request driver: one request in flight on the port, the next one loaded
  // straight after acceptance or after a drawn gap
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : request_driver
    request_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left    = 0;
    end else begin
      if (in_valid_i && !in_stall_o) record_request(cur_req);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0 || pending_requests.size() == 0) begin
          if (gap_left != 0) gap_left--;
          in_valid_i <= 1'b0;
        end else begin
          nxt            = pending_requests.pop_front();
          cur_req        = nxt;
          operation_i   <= nxt.op;
          entry_index_i <= nxt.idx;
          entry_key_i   <= nxt.key;
          entry_value_i <= nxt.val;
          in_valid_i    <= 1'b1;
          gap_left       = $urandom_range(0, snd_max_gap);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // result monitor: compares each accepted result with the oldest answer,
  // then stalls for a drawn number of cycles
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : result_monitor
    result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rcv_hold     = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (lookup_answers.size() == 0) begin
          $display("%0t: unexpected result, expected none, got hit %b key %h value %h",
                   $time, hit_o, found_key_o, found_value_o);
          err_cnt++;
        end else begin
          want = lookup_answers.pop_front();
          if (hit_o !== want.hit) begin
            $display("%0t: hit expected %b got %b", $time, want.hit, hit_o);
            err_cnt++;
          end
          if (found_key_o !== want.key) begin
            $display("%0t: found_key expected %h got %h", $time, want.key, found_key_o);
            err_cnt++;
          end
          if (found_value_o !== want.val) begin
            $display("%0t: found_value expected %h got %h", $time, want.val, found_value_o);
            err_cnt++;
          end
        end
        rcv_hold = $urandom_range(0, rcv_max_stall);
      end else if (rcv_hold != 0) begin
        rcv_hold--;
      end
      out_stall_i <= (rcv_hold != 0);
    end
  end

  // nothing accepted on either side for too long means the block hung
  always @(posedge clk_i) begin : stall_watchdog
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_sorted_table_binary_search_unit: errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // main sequence: reset, directed phases, then random phases each with
  // its own entry count and its own sorted table
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int unsigned      phase;
    int unsigned      n;
    int unsigned      len;
    int unsigned      j;
    int unsigned      stride;
    logic [KEY_W-1:0] k;

    foreach (plan_fresh[i]) plan_fresh[i] = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty table straight out of reset: the count is zero so both miss
    queue_lookup('0);
    queue_lookup('1);

    // four sorted entries with extreme keys and values, plus the last slot
    wait_idle();
    set_entry_count(4);
    queue_write(IDX_W'(0), 32'h0000_0000, 32'hFFFF_FFFF);
    queue_write(IDX_W'(1), 32'h0000_0005, 32'h0000_0001);
    queue_write(IDX_W'(2), 32'h8000_0000, 32'h0000_0000);
    queue_write(IDX_W'(3), 32'hFFFF_FFFF, 32'hA5A5_A5A5);
    queue_write(IDX_W'(TABLE_DEPTH - 1), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_lookup(32'h0000_0000);
    queue_lookup(32'h0000_0005);
    queue_lookup(32'h8000_0000);
    queue_lookup(32'hFFFF_FFFF);
    queue_lookup(32'h0000_0003);
    queue_lookup(32'h7FFF_FFFF);
    queue_lookup(32'hFFFF_FFFE);

    // single entry: one probe decides
    wait_idle();
    set_entry_count(1);
    queue_lookup(32'h0000_0000);
    queue_lookup(32'h0000_0005);

    // unsorted table: the larger key in the middle hides the one after it
    wait_idle();
    set_entry_count(3);
    queue_write(IDX_W'(1), 32'hFFFF_FFFF, 32'h1234_5678);
    queue_lookup(32'h8000_0000);
    queue_lookup(32'hFFFF_FFFF);

    // random phases; the first few take the count extremes, including
    // counts above the table depth which saturate
    phase = 0;
    while (n_queued < REQUEST_TARGET) begin
      case (phase)
        0: n = 2047;
        1: n = TABLE_DEPTH;
        2: n = 0;
        3: n = 1;
        default: begin
          case ($urandom_range(0, 9))
            0:       n = 0;
            1:       n = TABLE_DEPTH;
            2:       n = $urandom_range(TABLE_DEPTH + 1, 2047);
            3:       n = 1;
            4, 5:    n = $urandom_range(2, 200);
            default: n = $urandom_range(2, 16);
          endcase
        end
      endcase

      wait_idle();
      set_entry_count(n);

      // new sorted goal table: ascending keys with the odd duplicate,
      // strides sized so the last key cannot wrap
      stride = 32'hFFFF_FFFF / (plan_n + 1);
      k = ($urandom_range(0, 3) == 0) ? '0 : $urandom_range(0, stride);
      for (int i = 0; i < int'(plan_n); i++) begin
        if (i != 0) k = k + (($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, stride));
        goal_key[i] = k;
        goal_val[i] = $urandom;
      end
      if (plan_n != 0 && $urandom_range(0, 2) == 0) goal_key[plan_n - 1] = '1;
      foreach (plan_fresh[i]) plan_fresh[i] = 1'b0;

      // some phases run flat out on one side or both
      snd_max_gap   = (phase % 4 == 3) ? 0 : 5;
      rcv_max_stall = (phase % 3 == 2) ? 0 : 5;

      len = $urandom_range(20, 60);
      for (int i = 0; i < int'(len); i++) begin
        if ($urandom_range(0, 6) == 0) begin
          // stray write anywhere, which may also break the ordering
          queue_write(IDX_W'($urandom_range(0, TABLE_DEPTH - 1)), $urandom, $urandom);
        end else begin
          if (plan_n == 0) begin
            k = $urandom;
          end else begin
            j = $urandom_range(0, plan_n - 1);
            case ($urandom_range(0, 9))
              6:       k = goal_key[j] + 1;
              7:       k = goal_key[j] - 1;
              8:       k = $urandom;
              9:       k = $urandom_range(0, 1) ? '1 : '0;
              default: k = goal_key[j];
            endcase
          end
          queue_lookup(k);
        end
      end
      phase++;
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (err_cnt == 0 && lookup_answers.size() == 0) begin
      $display("tb_sorted_table_binary_search_unit: clean");
    end else begin
      $display("tb_sorted_table_binary_search_unit: errors");
    end
    $finish;
  end

endmodule
